// ----- src/mcc2d_pkg.sv -----
// Shared types and constants for the strided multichannel convolution core.
package mcc2d_pkg;

  localparam int WIDTH_MAX         = 256;
  localparam int HEIGHT_MAX        = 256;
  localparam int KERN_MAX          = 8;
  localparam int KERN_CHANNELS_MAX = 8;
  localparam int IN_CHANNELS_MAX   = 16;

  localparam int KADDR_W = $clog2(KERN_CHANNELS_MAX * KERN_MAX * KERN_MAX);
  localparam int LADDR_W = $clog2(KERN_MAX * WIDTH_MAX);
  localparam int KROW_W  = $clog2(KERN_MAX);
  localparam int COL_W   = $clog2(WIDTH_MAX);
  localparam int ROW_W   = $clog2(HEIGHT_MAX);
  localparam int SUM_W   = 38;
  localparam int PROD_W  = 32;

  localparam logic [2:0] REG_IN_HEIGHT     = 3'd0;
  localparam logic [2:0] REG_IN_WIDTH      = 3'd1;
  localparam logic [2:0] REG_IN_CHANNELS   = 3'd2;
  localparam logic [2:0] REG_KERN_CHANNELS = 3'd3;
  localparam logic [2:0] REG_KERN_HEIGHT   = 3'd4;
  localparam logic [2:0] REG_KERN_WIDTH    = 3'd5;
  localparam logic [2:0] REG_STRIDE        = 3'd6;

  localparam logic CMD_WEIGHT = 1'b0;
  localparam logic CMD_SAMPLE = 1'b1;

  // Control from the sequencer to the MAC datapath.
  typedef struct packed {
    logic clear;   // start a new sum with this product
    logic valid;   // a product pair is presented this cycle
  } mac_ctl_t;

endpackage

// ----- src/multichannel_conv2d_strided_core.sv -----
// Top level: strided valid 2D convolution, all input by all kernel channels.
// A weight is written when accepted; a sample is stored, and if it completes a window its
//   origin is divided by the stride; on the stride grid all kc kernel channels are summed and sent.
// Throughput: one transaction at a time; the stride divider and shared multiplier set the rate.
// Reset (rst, synchronous): sample counters clear and config returns to 8,8,1,1,3,3,1;
//   kernel and line stores stay unwritten and need no clearing pass.
module multichannel_conv2d_strided_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // tdata: weight_channel[2:0], weight_row[5:3], weight_col[8:6], value[24:9], zero fill
  input  logic [31:0] s_axis_tdata,
  // tuser: cmd[0]
  input  logic        s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // tdata: out_channel[6:0], out_row[14:7], out_col[22:15], sum[60:23], zero fill
  output logic [63:0] m_axis_tdata,
  output logic        m_axis_tlast,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [8:0]  cfg_data
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_CHECK = 6'b000010,
    S_MAC   = 6'b000100,
    S_DRAIN = 6'b001000,
    S_OUT   = 6'b010000,
    S_ADV   = 6'b100000
  } state_t;

  state_t state;

  // Configuration registers, held raw; clamped below.
  logic [8:0] in_height, in_width;
  logic [4:0] in_channels;
  logic [3:0] kern_channels, kern_height, kern_width, stride;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_height <= 9'd8; in_width <= 9'd8; in_channels <= 5'd1;
      kern_channels <= 4'd1; kern_height <= 4'd3; kern_width <= 4'd3; stride <= 4'd1;
    end else if (cfg_we) begin
      case (cfg_index)
        mcc2d_pkg::REG_IN_HEIGHT:     in_height     <= cfg_data;
        mcc2d_pkg::REG_IN_WIDTH:      in_width      <= cfg_data;
        mcc2d_pkg::REG_IN_CHANNELS:   in_channels   <= cfg_data[4:0];
        mcc2d_pkg::REG_KERN_CHANNELS: kern_channels <= cfg_data[3:0];
        mcc2d_pkg::REG_KERN_HEIGHT:   kern_height   <= cfg_data[3:0];
        mcc2d_pkg::REG_KERN_WIDTH:    kern_width    <= cfg_data[3:0];
        mcc2d_pkg::REG_STRIDE:        stride        <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // Clamp every register into its legal range.
  logic [8:0] h, w;
  logic [4:0] ic;
  logic [3:0] kc, kh, kw, st;
  always_comb begin
    h  = (in_height == 9'd0) ? 9'd1 : ((in_height > 9'd256) ? 9'd256 : in_height);
    w  = (in_width  == 9'd0) ? 9'd1 : ((in_width  > 9'd256) ? 9'd256 : in_width);
    ic = (in_channels == 5'd0) ? 5'd1 : ((in_channels > 5'd16) ? 5'd16 : in_channels);
    kc = (kern_channels == 4'd0) ? 4'd1 : ((kern_channels > 4'd8) ? 4'd8 : kern_channels);
    kh = (kern_height == 4'd0) ? 4'd1 : ((kern_height > 4'd8) ? 4'd8 : kern_height);
    kw = (kern_width  == 4'd0) ? 4'd1 : ((kern_width  > 4'd8) ? 4'd8 : kern_width);
    st = (stride == 4'd0) ? 4'd1 : ((stride > 4'd8) ? 4'd8 : stride);
  end

  // Input fields.
  logic              in_cmd;
  logic [2:0]        in_wch, in_wrow, in_wcol;
  logic signed [15:0] in_value;
  assign in_cmd   = s_axis_tuser;
  assign in_wch   = s_axis_tdata[2:0];
  assign in_wrow  = s_axis_tdata[5:3];
  assign in_wcol  = s_axis_tdata[8:6];
  assign in_value = s_axis_tdata[24:9];

  logic in_fire;
  assign s_axis_tready = (state == S_IDLE);
  assign in_fire = s_axis_tvalid && s_axis_tready;

  // Stores; each read registers its data.
  logic signed [15:0] kmem [mcc2d_pkg::KERN_CHANNELS_MAX*mcc2d_pkg::KERN_MAX*mcc2d_pkg::KERN_MAX];
  logic signed [15:0] lmem [mcc2d_pkg::KERN_MAX*mcc2d_pkg::WIDTH_MAX];
  logic signed [15:0] kq, lq;
  logic [mcc2d_pkg::KADDR_W-1:0] kaddr;
  logic [mcc2d_pkg::LADDR_W-1:0] laddr;

  // Sample counters (9 bits so a shrunken limit is seen as overflow).
  logic [8:0] srow, scol;
  logic [4:0] sch;
  logic [8:0] row, col;        // wrapped position of the current sample
  logic [4:0] chn;
  logic signed [15:0] sval;

  // Sequencer indexes and window origin.
  logic [2:0] kk, xx, yy;
  logic [8:0] r0, c0;
  logic [7:0] orow, ocol;
  logic [6:0] och_base;

  mcc2d_pkg::mac_ctl_t mctl;
  logic signed [mcc2d_pkg::SUM_W-1:0] acc;
  logic last_mac;

  // Divide the window origin by the stride in S_CHECK, one subtraction per cycle
  // on row and column together; a zero remainder on both puts it on the grid.
  logic [8:0] rrem, crem;
  logic [7:0] rq, cq;
  logic       origin_set;

  always_ff @(posedge clk) begin
    if (in_fire && in_cmd == mcc2d_pkg::CMD_WEIGHT) begin
      kmem[{in_wch, in_wrow, in_wcol}] <= in_value;
    end
    if (state == S_CHECK && !origin_set) begin
      lmem[{row[mcc2d_pkg::KROW_W-1:0], col[mcc2d_pkg::COL_W-1:0]}] <= sval;
    end
    kq <= kmem[kaddr];
    lq <= lmem[laddr];
  end

  logic [8:0] lrow;
  logic [8:0] lcol;
  assign lrow  = r0 + {6'd0, xx};
  assign lcol  = c0 + {6'd0, yy};
  assign kaddr = {kk, xx, yy};
  assign laddr = {lrow[mcc2d_pkg::KROW_W-1:0], lcol[mcc2d_pkg::COL_W-1:0]};

  logic win_ok;
  assign win_ok = (row + 9'd1 >= {5'd0, kh}) && (col + 9'd1 >= {5'd0, kw});

  logic [1:0] drain;
  logic [8:0] srow_n, scol_n;
  logic [4:0] sch_n;

  always_comb begin
    scol_n = col + 9'd1; srow_n = row; sch_n = chn;
    if (scol_n >= w) begin
      scol_n = 9'd0; srow_n = row + 9'd1;
      if (srow_n >= h) begin
        srow_n = 9'd0; sch_n = chn + 5'd1;
        if (sch_n >= ic) sch_n = 5'd0;
      end
    end
  end

  assign last_mac = (xx == 3'(kh - 4'd1)) && (yy == 3'(kw - 4'd1));
  assign mctl = '{clear: (state == S_MAC) && (xx == 3'd0) && (yy == 3'd0),
                  valid: (state == S_MAC)};

  // Pipeline of kq/lq: addresses in S_MAC, data in the following cycle; delay control.
  mcc2d_pkg::mac_ctl_t mctl_d;
  always_ff @(posedge clk) begin
    if (rst) mctl_d <= '0;
    else     mctl_d <= mctl;
  end

  mcc2d_mac u_mac (
    .clk (clk),
    .ctl (mctl_d),
    .a   (lq),
    .b   (kq),
    .acc (acc)
  );

  logic [6:0]  o_ch;
  logic [7:0]  o_row, o_col;
  logic signed [mcc2d_pkg::SUM_W-1:0] o_sum;
  logic        o_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE; srow <= 9'd0; scol <= 9'd0; sch <= 5'd0;
      m_axis_tvalid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_fire && in_cmd == mcc2d_pkg::CMD_SAMPLE) begin
            row  <= (srow >= h) ? 9'd0 : srow;
            col  <= (scol >= w) ? 9'd0 : scol;
            chn  <= (sch >= ic) ? 5'd0 : sch;
            sval <= in_value;
            origin_set <= 1'b0;
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          // On entry: store the sample, take origins. Then divide by stride if a window fits.
          if (!origin_set) begin
            origin_set <= 1'b1;
            r0 <= row + 9'd1 - {5'd0, kh};
            c0 <= col + 9'd1 - {5'd0, kw};
            rrem <= row + 9'd1 - {5'd0, kh};
            crem <= col + 9'd1 - {5'd0, kw};
            rq <= 8'd0; cq <= 8'd0;
            if (!win_ok) begin
              state <= S_ADV;
            end
          end else if (rrem >= {5'd0, st} || crem >= {5'd0, st}) begin
            if (rrem >= {5'd0, st}) begin rrem <= rrem - {5'd0, st}; rq <= rq + 8'd1; end
            if (crem >= {5'd0, st}) begin crem <= crem - {5'd0, st}; cq <= cq + 8'd1; end
          end else begin
            if (rrem == 9'd0 && crem == 9'd0) begin
              orow <= rq; ocol <= cq;
              och_base <= {2'd0, chn} * {3'd0, kc};
              kk <= 3'd0; xx <= 3'd0; yy <= 3'd0;
              state <= S_MAC;
            end else begin
              state <= S_ADV;
            end
          end
        end
        S_MAC: begin
          if (last_mac) begin
            xx <= 3'd0; yy <= 3'd0; drain <= 2'd0;
            state <= S_DRAIN;
          end else if (yy == 3'(kw - 4'd1)) begin
            yy <= 3'd0; xx <= xx + 3'd1;
          end else begin
            yy <= yy + 3'd1;
          end
        end
        S_DRAIN: begin
          drain <= drain + 2'd1;
          if (drain == 2'd2) begin
            o_ch   <= och_base + {4'd0, kk};
            o_row  <= orow; o_col <= ocol;
            o_sum  <= acc;
            o_last <= ({1'b0, kk} + 4'd1 == kc);
            m_axis_tvalid <= 1'b1;
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (m_axis_tready) begin
            m_axis_tvalid <= 1'b0;
            if (o_last) begin
              state <= S_ADV;
            end else begin
              kk <= kk + 3'd1;
              state <= S_MAC;
            end
          end
        end
        S_ADV: begin
          srow <= srow_n; scol <= scol_n; sch <= sch_n;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign m_axis_tdata = {3'd0, o_sum, o_col, o_row, o_ch};
  assign m_axis_tlast = o_last;

endmodule

// ----- src/mcc2d_mac.sv -----
// Shared multiply-accumulate unit: registered product, then accumulate.
module mcc2d_mac (
  input  logic                           clk,
  input  mcc2d_pkg::mac_ctl_t            ctl,
  input  logic signed [15:0]             a,
  input  logic signed [15:0]             b,
  output logic signed [mcc2d_pkg::SUM_W-1:0] acc
);

  logic signed [mcc2d_pkg::PROD_W-1:0] prod;
  logic                                prod_valid;
  logic                                prod_clear;

  always_ff @(posedge clk) begin
    prod       <= a * b;
    prod_valid <= ctl.valid;
    prod_clear <= ctl.clear;
    if (prod_valid) begin
      if (prod_clear) begin
        acc <= mcc2d_pkg::SUM_W'(prod);
      end else begin
        acc <= acc + mcc2d_pkg::SUM_W'(prod);
      end
    end
  end

endmodule

// ----- src/mcc2d_checker.sv -----
// Port-level checks for the convolution core, bound to the top level.
module mcc2d_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        s_axis_tuser,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [63:0] m_axis_tdata,
  input logic        m_axis_tlast
);

  a_no_ready_while_out: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !s_axis_tready) else $error("input ready during output");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tlast)) else $error("output changed while stalled");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid) else $error("output valid after reset");

  a_busy_after_sample: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready && (s_axis_tuser == mcc2d_pkg::CMD_SAMPLE)
      |=> !s_axis_tready) else $error("ready right after sample accept");

endmodule

bind multichannel_conv2d_strided_core mcc2d_checker u_mcc2d_checker (
  .clk (clk), .rst (rst),
  .s_axis_tvalid (s_axis_tvalid), .s_axis_tready (s_axis_tready),
  .s_axis_tuser (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid), .m_axis_tready (m_axis_tready),
  .m_axis_tdata (m_axis_tdata), .m_axis_tlast (m_axis_tlast)
);

// ----- sim/tb_multichannel_conv2d_strided_core.sv -----
// Testbench for the strided multichannel 2D convolution core.
`timescale 1ns / 1ps

module tb_multichannel_conv2d_strided_core;

  typedef struct packed {
    logic [6:0]  chan;
    logic [7:0]  row;
    logic [7:0]  col;
    logic [37:0] sum;
    logic        last;
  } conv_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic        s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [63:0] m_axis_tdata;
  logic        m_axis_tlast;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = mcc2d_pkg::REG_IN_HEIGHT;
  logic [8:0]  cfg_data = '0;

  // Shadow copy of the core state, kept by the predictor and by write_reg.
  logic [8:0]         shadow_reg [0:6];
  logic signed [15:0] kern_mem [0:mcc2d_pkg::KERN_CHANNELS_MAX*mcc2d_pkg::KERN_MAX*
                                  mcc2d_pkg::KERN_MAX-1];
  logic signed [15:0] line_mem [0:mcc2d_pkg::KERN_MAX*mcc2d_pkg::WIDTH_MAX-1];
  int unsigned        cur_row, cur_col, cur_chan;

  conv_result_t pending_sums[$];
  int           src_idle_pct, snk_idle_pct;
  int           mismatches, results_seen, items_sent, windows_hit;

  always #5 clk = ~clk;

  multichannel_conv2d_strided_core u_dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  function automatic int unsigned clamp_reg(int unsigned v, int unsigned lo, int unsigned hi);
    return (v < lo) ? lo : (v > hi) ? hi : v;
  endfunction

  // Advance the shadow state by one item and queue the window sums it completes.
  function automatic void conv_predict(logic cmd, logic [31:0] item);
    int unsigned h, w, ic, kc, kh, kw, st, r0, c0;
    logic signed [63:0] acc;
    conv_result_t res;
    h  = clamp_reg(shadow_reg[mcc2d_pkg::REG_IN_HEIGHT], 1, mcc2d_pkg::HEIGHT_MAX);
    w  = clamp_reg(shadow_reg[mcc2d_pkg::REG_IN_WIDTH], 1, mcc2d_pkg::WIDTH_MAX);
    ic = clamp_reg(shadow_reg[mcc2d_pkg::REG_IN_CHANNELS], 1, mcc2d_pkg::IN_CHANNELS_MAX);
    kc = clamp_reg(shadow_reg[mcc2d_pkg::REG_KERN_CHANNELS], 1, mcc2d_pkg::KERN_CHANNELS_MAX);
    kh = clamp_reg(shadow_reg[mcc2d_pkg::REG_KERN_HEIGHT], 1, mcc2d_pkg::KERN_MAX);
    kw = clamp_reg(shadow_reg[mcc2d_pkg::REG_KERN_WIDTH], 1, mcc2d_pkg::KERN_MAX);
    st = clamp_reg(shadow_reg[mcc2d_pkg::REG_STRIDE], 1, 8);
    if (cmd == mcc2d_pkg::CMD_WEIGHT) begin
      kern_mem[{item[2:0], item[5:3], item[8:6]}] = item[24:9];
      return;
    end
    if (cur_row >= h) cur_row = 0;
    if (cur_col >= w) cur_col = 0;
    if (cur_chan >= ic) cur_chan = 0;
    line_mem[(cur_row % mcc2d_pkg::KERN_MAX) * mcc2d_pkg::WIDTH_MAX + cur_col] = item[24:9];
    if (cur_row + 1 >= kh && cur_col + 1 >= kw &&
        (cur_row + 1 - kh) % st == 0 && (cur_col + 1 - kw) % st == 0) begin
      r0 = cur_row + 1 - kh;
      c0 = cur_col + 1 - kw;
      windows_hit++;
      for (int k = 0; k < kc; k++) begin
        acc = 0;
        for (int x = 0; x < kh; x++)
          for (int y = 0; y < kw; y++)
            acc += line_mem[((r0 + x) % mcc2d_pkg::KERN_MAX) * mcc2d_pkg::WIDTH_MAX + c0 + y] *
                   kern_mem[(k * mcc2d_pkg::KERN_MAX + x) * mcc2d_pkg::KERN_MAX + y];
        res.chan = 7'(cur_chan * kc + k);
        res.row  = 8'(r0 / st);
        res.col  = 8'(c0 / st);
        res.sum  = acc[37:0];
        res.last = (k + 1 == kc);
        pending_sums.push_back(res);
      end
    end
    cur_col++;
    if (cur_col >= w) begin
      cur_col = 0;
      cur_row++;
      if (cur_row >= h) begin
        cur_row = 0;
        cur_chan++;
        if (cur_chan >= ic) cur_chan = 0;
      end
    end
  endfunction

  // Offer one item; hold tvalid high across back-to-back transactions.
  task automatic send_item(logic cmd, logic [2:0] wch, logic [2:0] wrow, logic [2:0] wcol,
                           logic [15:0] value);
    if ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < src_idle_pct);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= {7'b0, value, wcol, wrow, wch};
    do @(posedge clk); while (!s_axis_tready);
    items_sent++;
    conv_predict(cmd, {7'b0, value, wcol, wrow, wch});
  endtask

  task automatic send_sample(logic [15:0] value);
    send_item(mcc2d_pkg::CMD_SAMPLE, 3'($urandom), 3'($urandom), 3'($urandom), value);
  endtask

  // Drop valid, wait for every queued sum and for the core to be idle again.
  task automatic drain;
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_sums.size() != 0 || !s_axis_tready) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // Present one register write; the caller drops the write enable afterwards.
  task automatic write_reg(logic [2:0] idx, logic [8:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    shadow_reg[idx] = value;
  endtask

  task automatic set_geometry(int h, int w, int ic, int kc, int kh, int kw, int st);
    write_reg(mcc2d_pkg::REG_IN_HEIGHT, 9'(h));
    write_reg(mcc2d_pkg::REG_IN_WIDTH, 9'(w));
    write_reg(mcc2d_pkg::REG_IN_CHANNELS, 9'(ic));
    write_reg(mcc2d_pkg::REG_KERN_CHANNELS, 9'(kc));
    write_reg(mcc2d_pkg::REG_KERN_HEIGHT, 9'(kh));
    write_reg(mcc2d_pkg::REG_KERN_WIDTH, 9'(kw));
    write_reg(mcc2d_pkg::REG_STRIDE, 9'(st));
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Load random weights into every tap the current geometry reads.
  task automatic load_kernels;
    int kc, kh, kw;
    kc = clamp_reg(shadow_reg[mcc2d_pkg::REG_KERN_CHANNELS], 1, mcc2d_pkg::KERN_CHANNELS_MAX);
    kh = clamp_reg(shadow_reg[mcc2d_pkg::REG_KERN_HEIGHT], 1, mcc2d_pkg::KERN_MAX);
    kw = clamp_reg(shadow_reg[mcc2d_pkg::REG_KERN_WIDTH], 1, mcc2d_pkg::KERN_MAX);
    for (int k = 0; k < kc; k++)
      for (int x = 0; x < kh; x++)
        for (int y = 0; y < kw; y++)
          send_item(mcc2d_pkg::CMD_WEIGHT, 3'(k), 3'(x), 3'(y), 16'($urandom));
  endtask

  // Out-of-range register values clamp: 1x1 frames and taps, 16 channels by 8 kernels,
  // so the map index reaches 127; field extremes give the largest sums of both signs.
  task automatic test_register_clamp;
    set_geometry(0, 0, 31, 15, 0, 0, 15);
    for (int k = 0; k < 8; k++)
      send_item(mcc2d_pkg::CMD_WEIGHT, 3'(k), 3'd7, 3'd7, 16'h7FFF);
    for (int k = 0; k < 8; k++)
      send_item(mcc2d_pkg::CMD_WEIGHT, 3'(k), 3'd0, 3'd0, (k % 2) ? 16'h8000 : 16'h7FFF);
    for (int i = 0; i < 16; i++)
      send_sample((i % 3 == 0) ? 16'h8000 : (i % 3 == 1) ? 16'h7FFF : 16'h0000);
    drain();
  endtask

  // A kernel bigger than the frame never completes a window.
  task automatic test_kernel_too_large;
    set_geometry(2, 2, 1, 1, 3, 3, 1);
    for (int i = 0; i < 4; i++) send_sample(16'($urandom));
    drain();
  endtask

  // Random geometries, whole frames of random samples, some stray weight writes.
  task automatic test_random_frames(int min_items);
    int start, frame;
    start = items_sent;
    while (items_sent < start + min_items) begin
      set_geometry($urandom_range(1, 4), $urandom_range(1, 6), $urandom_range(1, 2),
                   $urandom_range(1, 4), $urandom_range(1, 3), $urandom_range(1, 3),
                   $urandom_range(1, 3));
      load_kernels();
      frame = clamp_reg(shadow_reg[mcc2d_pkg::REG_IN_HEIGHT], 1, mcc2d_pkg::HEIGHT_MAX) *
              clamp_reg(shadow_reg[mcc2d_pkg::REG_IN_WIDTH], 1, mcc2d_pkg::WIDTH_MAX) *
              clamp_reg(shadow_reg[mcc2d_pkg::REG_IN_CHANNELS], 1,
                        mcc2d_pkg::IN_CHANNELS_MAX);
      for (int i = 0; i < frame; i++) begin
        if ($urandom_range(9) == 0)
          send_item(mcc2d_pkg::CMD_WEIGHT, 3'($urandom), 3'($urandom), 3'($urandom),
                    16'($urandom));
        send_sample(16'($urandom));
      end
      // Hold off until the core is idle before touching the registers again.
      drain();
    end
  endtask

  // Check each result transaction against the oldest queued sum; randomize backpressure.
  always @(posedge clk) begin
    conv_result_t exp_r, got;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = {m_axis_tdata[6:0], m_axis_tdata[14:7], m_axis_tdata[22:15],
             m_axis_tdata[60:23], m_axis_tlast};
      results_seen++;
      if (pending_sums.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", got);
      end else begin
        exp_r = pending_sums.pop_front();
        if (got !== exp_r || m_axis_tdata[63:61] !== 3'b0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected %p, got %p", exp_r, got);
        end
      end
    end
    m_axis_tready <= ($urandom_range(99) >= snk_idle_pct);
  end

  initial begin
    shadow_reg[mcc2d_pkg::REG_IN_HEIGHT] = 8;
    shadow_reg[mcc2d_pkg::REG_IN_WIDTH] = 8;
    shadow_reg[mcc2d_pkg::REG_IN_CHANNELS] = 1;
    shadow_reg[mcc2d_pkg::REG_KERN_CHANNELS] = 1;
    shadow_reg[mcc2d_pkg::REG_KERN_HEIGHT] = 3;
    shadow_reg[mcc2d_pkg::REG_KERN_WIDTH] = 3;
    shadow_reg[mcc2d_pkg::REG_STRIDE] = 1;
    cur_row = 0; cur_col = 0; cur_chan = 0;
    mismatches = 0; results_seen = 0; items_sent = 0; windows_hit = 0;
    src_idle_pct = 14; snk_idle_pct = 88;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_register_clamp();
    test_kernel_too_large();
    test_random_frames(22);
    src_idle_pct = 88; snk_idle_pct = 14;
    test_random_frames(22);
    src_idle_pct = 0; snk_idle_pct = 0;
    test_random_frames(22);
    $display("covered %0d input transactions, %0d windows, %0d result transactions",
             items_sent, windows_hit, results_seen);
    if (mismatches == 0 && pending_sums.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("simulation failed");
    $finish;
  end

endmodule
